@@ sv/rsfc_pkg.sv @@
`default_nettype none

package rsfc_pkg;

    // Receive buffer length: a burst of this many bytes or more is overlong
    localparam int BUF_LEN      = 128;
    localparam int MIN_BURST    = 21;
    localparam int PAYLOAD_BASE = 17;
    localparam int COUNT_W      = 9;
    localparam int CNT_EXT_W    = COUNT_W + 1;
    localparam int CFG_IDX_W    = 8;

    localparam logic [7:0] CRC_POLY      = 8'h8C;
    localparam logic [7:0] HEADER_RESET  = 8'hAA;
    localparam logic [7:0] TAIL_RESET    = 8'hBB;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] IDX_ID    = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] IDX_LEN   = COUNT_W'(16);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HEADER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TAIL   = CFG_IDX_W'(1);

    // Frame status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_OVERLONG = 3'd2;
    localparam logic [2:0] ST_HEADER   = 3'd3;
    localparam logic [2:0] ST_TAIL     = 3'd4;
    localparam logic [2:0] ST_CRC      = 3'd5;
    localparam logic [2:0] ST_TRUNC    = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       burst_end;
    } in_t;

    typedef struct packed {
        logic [2:0] status;
        logic       frame_ok;
        logic [7:0] trans_id;
        logic [7:0] payload_len;
    } out_t;

    // Reflected CRC-8, one byte per call
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ sv/rs485_frame_checker.sv @@
`default_nettype none

// RS-485 burst checker.
// Feed the bytes of one received burst on the s_ channel, one byte per beat,
// with burst_end set on the last byte before the line went idle. On that byte
// one result beat leaves on the m_ channel: status, frame_ok, the transaction
// id (byte 2) and the payload length (byte 16). Other bytes give no result.
// The cfg_ channel writes the header byte (index 0) and tail byte (index 1);
// write them only while no burst is in flight. cfg_ready is always high.
// A byte taken into the input register is checked and folded into the CRC
// from there; a burst_end byte's result goes into the result register and
// shows on m_valid. Throughput is one byte per cycle, set by the single-byte
// CRC-8 update, while no final byte waits on a stalled result register.
// Reset clears the burst state, loads 0xAA / 0xBB into the registers and
// empties both the input and result registers.
// When the receiver stalls, bytes without burst_end keep flowing; a burst_end
// byte waits in the input register until the result register is free, and
// s_ready drops meanwhile.
module rs485_frame_checker (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  rsfc_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  wire                               m_ready,
    output rsfc_pkg::out_t                    m_data,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [rsfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [7:0]                        cfg_data
);

    logic [7:0] header_reg;
    logic [7:0] tail_reg;

    logic           in_valid_reg;
    rsfc_pkg::in_t  in_reg;
    logic           adv;

    logic [rsfc_pkg::COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0] running_crc_reg, running_crc_next;
    logic       header_good_reg, header_good_next;
    logic       tail_good_reg, tail_good_next;
    logic       crc_good_reg, crc_good_next;
    logic [7:0] captured_len_reg, captured_len_next;
    logic [7:0] captured_id_reg, captured_id_next;

    logic           out_valid_reg, out_valid_next;
    rsfc_pkg::out_t out_reg, out_next;

    logic [rsfc_pkg::CNT_EXT_W-1:0] idx;
    logic [rsfc_pkg::CNT_EXT_W-1:0] end_pos;
    logic [rsfc_pkg::CNT_EXT_W-1:0] count;
    logic [2:0] status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= rsfc_pkg::HEADER_RESET;
            tail_reg   <= rsfc_pkg::TAIL_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == rsfc_pkg::REG_HEADER) begin
                header_reg <= cfg_data;
            end
            if (cfg_index == rsfc_pkg::REG_TAIL) begin
                tail_reg <= cfg_data;
            end
        end
    end

    // A non-final byte never needs the result register
    assign adv     = in_valid_reg && (!in_reg.burst_end || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    assign idx     = {1'b0, byte_count_reg};
    assign end_pos = rsfc_pkg::CNT_EXT_W'(rsfc_pkg::PAYLOAD_BASE)
                     + {{(rsfc_pkg::CNT_EXT_W-8){1'b0}}, captured_len_reg};

    always_comb begin
        byte_count_next   = byte_count_reg;
        running_crc_next  = running_crc_reg;
        header_good_next  = header_good_reg;
        tail_good_next    = tail_good_reg;
        crc_good_next     = crc_good_reg;
        captured_len_next = captured_len_reg;
        captured_id_next  = captured_id_reg;
        count             = idx + rsfc_pkg::CNT_EXT_W'(1);
        status            = rsfc_pkg::ST_OK;
        out_valid_next    = out_valid_reg && !m_ready;
        out_next          = out_reg;

        if (adv) begin
            if (idx < rsfc_pkg::CNT_EXT_W'(2) && in_reg.data_byte != header_reg) begin
                header_good_next = 1'b0;
            end
            if (byte_count_reg == rsfc_pkg::IDX_ID) begin
                captured_id_next = in_reg.data_byte;
            end
            if (byte_count_reg == rsfc_pkg::IDX_LEN) begin
                captured_len_next = in_reg.data_byte;
            end
            if (idx >= rsfc_pkg::CNT_EXT_W'(rsfc_pkg::PAYLOAD_BASE)) begin
                if ((idx == end_pos || idx == end_pos + rsfc_pkg::CNT_EXT_W'(1))
                    && in_reg.data_byte != tail_reg) begin
                    tail_good_next = 1'b0;
                end
                if (idx == end_pos + rsfc_pkg::CNT_EXT_W'(2)) begin
                    crc_good_next = (in_reg.data_byte == running_crc_reg);
                end
            end
            if (idx < rsfc_pkg::CNT_EXT_W'(rsfc_pkg::PAYLOAD_BASE)
                || idx <= end_pos + rsfc_pkg::CNT_EXT_W'(1)) begin
                running_crc_next = rsfc_pkg::crc8_update(running_crc_reg, in_reg.data_byte);
            end
            if (byte_count_reg != rsfc_pkg::COUNT_MAX) begin
                byte_count_next = byte_count_reg + rsfc_pkg::COUNT_W'(1);
            end

            if (in_reg.burst_end) begin
                if (count < rsfc_pkg::CNT_EXT_W'(rsfc_pkg::MIN_BURST)) begin
                    status = rsfc_pkg::ST_SHORT;
                end else if (count >= rsfc_pkg::CNT_EXT_W'(rsfc_pkg::BUF_LEN)) begin
                    status = rsfc_pkg::ST_OVERLONG;
                end else if (!header_good_next) begin
                    status = rsfc_pkg::ST_HEADER;
                end else if (count < rsfc_pkg::CNT_EXT_W'(rsfc_pkg::PAYLOAD_BASE + 3)
                             + {{(rsfc_pkg::CNT_EXT_W-8){1'b0}}, captured_len_next}) begin
                    status = rsfc_pkg::ST_TRUNC;
                end else if (!tail_good_next) begin
                    status = rsfc_pkg::ST_TAIL;
                end else if (!crc_good_next) begin
                    status = rsfc_pkg::ST_CRC;
                end else begin
                    status = rsfc_pkg::ST_OK;
                end

                out_valid_next       = 1'b1;
                out_next.status      = status;
                out_next.frame_ok    = (status == rsfc_pkg::ST_OK);
                out_next.trans_id    = captured_id_next;
                out_next.payload_len = captured_len_next;

                // Start the next burst from scratch
                byte_count_next   = '0;
                running_crc_next  = '0;
                header_good_next  = 1'b1;
                tail_good_next    = 1'b1;
                crc_good_next     = 1'b0;
                captured_len_next = '0;
                captured_id_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            running_crc_reg  <= '0;
            header_good_reg  <= 1'b1;
            tail_good_reg    <= 1'b1;
            crc_good_reg     <= 1'b0;
            captured_len_reg <= '0;
            captured_id_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            byte_count_reg   <= byte_count_next;
            running_crc_reg  <= running_crc_next;
            header_good_reg  <= header_good_next;
            tail_good_reg    <= tail_good_next;
            crc_good_reg     <= crc_good_next;
            captured_len_reg <= captured_len_next;
            captured_id_reg  <= captured_id_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_ok_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.frame_ok == (m_data.status == rsfc_pkg::ST_OK)))
        else $error("frame_ok disagrees with status");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status <= rsfc_pkg::ST_TRUNC))
        else $error("status code out of range");

    a_burst_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_reg.burst_end) |=>
            (byte_count_reg == '0 && running_crc_reg == '0 && header_good_reg))
        else $error("burst state not cleared after final byte");

    a_end_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_reg.burst_end && out_valid_reg && !m_ready)
            |=> (in_valid_reg && m_valid))
        else $error("final byte dropped while result stalled");

endmodule

`default_nettype wire
